// ----- sv/skinny_gemm_tile_mac_defines.svh -----
// Assertion macros for the skinny GEMM tile engine.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef SKINNY_GEMM_TILE_MAC_DEFINES_SVH
`define SKINNY_GEMM_TILE_MAC_DEFINES_SVH

`ifndef SYNTH
`define SGTM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SGTM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SGTM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SGTM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- sv/sgtm_pkg.sv -----
// Shared types and constants of the skinny GEMM tile engine.
// Used by the front, queue, back and top-level modules.
package sgtm_pkg;

   localparam int TILE_ROWS   = 4;
   localparam int TILE_COLS   = 2;
   localparam int NUM_A       = 4;
   localparam int NUM_B       = 2;
   localparam int DATA_W      = 16;
   localparam int C_W         = 32;
   localparam int ACC_W       = 48;
   localparam int BPROD_W     = DATA_W + C_W;
   localparam int OFF_W       = 17;
   localparam int ROW_W       = 2;
   localparam int LD_W        = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 56;

   localparam logic [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};
   localparam logic [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};

   typedef enum logic {
      KIND_KSTEP  = 1'b0,
      KIND_FINISH = 1'b1
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BETA      = 2'd0,
      CSR_ROW_MAJOR = 2'd1,
      CSR_LEAD_DIM  = 2'd2,
      CSR_COLS      = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] beta;
      logic                     row_major;
      logic [LD_W-1:0]          leading_dim;
      logic [1:0]               columns_in_use;
   } cfg_type;

   typedef struct packed {
      kind_type                         kind;
      logic [NUM_A-1:0][DATA_W-1:0]     a;
      logic [NUM_B-1:0][DATA_W-1:0]     b;
      logic [C_W-1:0]                   c_old;
      logic [ROW_W-1:0]                 row;
      logic                             col;
      logic                             tile_end;
      logic                             in_tile;
      logic [TILE_COLS-1:0]             col_en;
      logic [OFF_W-1:0]                 offset;
   } item_type;

   typedef struct packed {
      logic [C_W-1:0]   c_new;
      logic [ROW_W-1:0] row;
      logic             col;
      logic [OFF_W-1:0] offset;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic s1_valid;
      logic s1_finish;
      logic advance;
   } bstat_type;

endpackage

// ----- sv/sgtm_front.sv -----
// Front end: takes request transactions, unpacks and classifies them, works out
// the C offset and lane enables. Depends on sgtm_pkg.
module sgtm_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sgtm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tuser,
   input  logic                               req_tlast,
   input  sgtm_pkg::cfg_type                  cfg,
   input  logic                               q_full,
   output logic                               q_push,
   output sgtm_pkg::item_type                 q_item
);

   localparam int B_LSB   = sgtm_pkg::NUM_A * sgtm_pkg::DATA_W;
   localparam int C_LSB   = B_LSB + sgtm_pkg::NUM_B * sgtm_pkg::DATA_W;
   localparam int ROW_LSB = C_LSB + sgtm_pkg::C_W;
   localparam int COL_LSB = ROW_LSB + sgtm_pkg::ROW_W;

   logic               f_valid_ff, f_valid_in;
   sgtm_pkg::item_type f_item_ff, f_item_in;
   logic               accept;
   logic               two_cols;

   assign req_tready = !f_valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = f_valid_ff && !q_full;
   assign q_item     = f_item_ff;
   assign two_cols   = (cfg.columns_in_use != 2'd1);

   always_comb begin
      f_item_in.kind = sgtm_pkg::kind_type'(req_tuser);
      for (int r = 0; r < sgtm_pkg::NUM_A; r++) begin
         f_item_in.a[r] = req_tdata[r*sgtm_pkg::DATA_W +: sgtm_pkg::DATA_W];
      end
      for (int c = 0; c < sgtm_pkg::NUM_B; c++) begin
         f_item_in.b[c] = req_tdata[B_LSB + c*sgtm_pkg::DATA_W +: sgtm_pkg::DATA_W];
      end
      f_item_in.c_old    = req_tdata[C_LSB +: sgtm_pkg::C_W];
      f_item_in.row      = req_tdata[ROW_LSB +: sgtm_pkg::ROW_W];
      f_item_in.col      = req_tdata[COL_LSB];
      f_item_in.tile_end = req_tlast;
      f_item_in.in_tile  = (32'(f_item_in.row) < sgtm_pkg::TILE_ROWS) &&
                           (32'(f_item_in.col) < sgtm_pkg::TILE_COLS);
      for (int c = 0; c < sgtm_pkg::TILE_COLS; c++) begin
         f_item_in.col_en[c] = (c < sgtm_pkg::NUM_B) && ((c == 0) || two_cols);
      end
      if (cfg.row_major) begin
         if (two_cols) begin
            f_item_in.offset = sgtm_pkg::OFF_W'({f_item_in.row, 1'b0}) +
                               sgtm_pkg::OFF_W'(f_item_in.col);
         end else begin
            f_item_in.offset = sgtm_pkg::OFF_W'(f_item_in.row) +
                               sgtm_pkg::OFF_W'(f_item_in.col);
         end
      end else begin
         if (f_item_in.col) begin
            f_item_in.offset = sgtm_pkg::OFF_W'(cfg.leading_dim) +
                               sgtm_pkg::OFF_W'(f_item_in.row);
         end else begin
            f_item_in.offset = sgtm_pkg::OFF_W'(f_item_in.row);
         end
      end
   end

   always_comb begin
      priority if (accept) begin
         f_valid_in = 1'b1;
      end else if (q_push) begin
         f_valid_in = 1'b0;
      end else begin
         f_valid_in = f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_item_ff <= f_item_in;
      end
   end

endmodule

// ----- sv/sgtm_queue.sv -----
// Short FIFO of decoded items between the front end and the back end.
// Depends on sgtm_pkg.
module sgtm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sgtm_pkg::item_type    push_item,
   input  logic                  pop,
   output sgtm_pkg::item_type    head_item,
   output sgtm_pkg::qstat_type   stat
);

   sgtm_pkg::item_type            mem [sgtm_pkg::QUEUE_DEPTH];
   logic [sgtm_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sgtm_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sgtm_pkg::QCNT_W-1:0]   count_ff, count_in;

   localparam logic [sgtm_pkg::QPTR_W-1:0] LAST_PTR =
      sgtm_pkg::QPTR_W'(sgtm_pkg::QUEUE_DEPTH - 1);

   assign stat.full  = (count_ff == sgtm_pkg::QCNT_W'(sgtm_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_item  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/sgtm_back.sv -----
// Back end: multiply stage, accumulator bank and finish arithmetic with the
// response register. Depends on sgtm_pkg.
module sgtm_back (
   input  logic                               clock,
   input  logic                               reset,
   input  sgtm_pkg::item_type                 head_item,
   input  logic                               q_empty,
   output logic                               q_pop,
   input  logic signed [sgtm_pkg::DATA_W-1:0] beta,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output sgtm_pkg::rsp_type                  rsp_item,
   output sgtm_pkg::bstat_type                stat
);

   localparam int PROD_W = 2 * sgtm_pkg::DATA_W;
   localparam int BSH_W  = sgtm_pkg::BPROD_W - 14;
   localparam int ASH_W  = sgtm_pkg::ACC_W - 15;
   localparam int SUM_W  = BSH_W + 1;

   logic advance;

   logic                             s1_valid_ff, s1_valid_in;
   sgtm_pkg::kind_type               s1_kind_ff;
   logic [sgtm_pkg::ROW_W-1:0]       s1_row_ff;
   logic                             s1_col_ff;
   logic                             s1_tile_end_ff;
   logic                             s1_in_tile_ff;
   logic [sgtm_pkg::TILE_COLS-1:0]   s1_col_en_ff;
   logic [sgtm_pkg::OFF_W-1:0]       s1_offset_ff;
   logic signed [PROD_W-1:0]         s1_prod_ff [sgtm_pkg::TILE_ROWS][sgtm_pkg::TILE_COLS];
   logic signed [sgtm_pkg::BPROD_W-1:0] s1_bprod_ff;

   logic signed [sgtm_pkg::ACC_W-1:0] acc_ff [sgtm_pkg::TILE_ROWS][sgtm_pkg::TILE_COLS];
   logic signed [sgtm_pkg::ACC_W-1:0] acc_in [sgtm_pkg::TILE_ROWS][sgtm_pkg::TILE_COLS];

   logic                     rsp_valid_ff, rsp_valid_in;
   sgtm_pkg::rsp_type        rsp_ff, rsp_in;

   logic signed [sgtm_pkg::ACC_W-1:0] acc_sel;
   logic signed [sgtm_pkg::BPROD_W-1:0] bprod_shr;
   logic signed [sgtm_pkg::ACC_W-1:0] acc_shr;
   logic [BSH_W-1:0]         bprod_sh;
   logic [ASH_W-1:0]         acc_sh;
   logic [SUM_W-1:0]         sum;
   logic                     s1_finish;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign q_pop      = advance && !q_empty;
   assign s1_finish  = (s1_kind_ff == sgtm_pkg::KIND_FINISH);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   assign stat.s1_valid  = s1_valid_ff;
   assign stat.s1_finish = s1_finish;
   assign stat.advance   = advance;

   assign s1_valid_in = advance ? q_pop : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_kind_ff     <= head_item.kind;
         s1_row_ff      <= head_item.row;
         s1_col_ff      <= head_item.col;
         s1_tile_end_ff <= head_item.tile_end;
         s1_in_tile_ff  <= head_item.in_tile;
         s1_col_en_ff   <= head_item.col_en;
         s1_offset_ff   <= head_item.offset;
         s1_bprod_ff    <= beta * $signed(head_item.c_old);
         for (int r = 0; r < sgtm_pkg::TILE_ROWS; r++) begin
            for (int c = 0; c < sgtm_pkg::TILE_COLS; c++) begin
               s1_prod_ff[r][c] <= $signed(head_item.a[r]) * $signed(head_item.b[c]);
            end
         end
      end
   end

   // finish arithmetic
   always_comb begin
      acc_sel   = s1_in_tile_ff ? acc_ff[s1_row_ff][s1_col_ff] : '0;
      bprod_shr = s1_bprod_ff >>> 14;
      acc_shr   = acc_sel >>> 15;
      bprod_sh  = bprod_shr[BSH_W-1:0];
      acc_sh    = acc_shr[ASH_W-1:0];
      sum       = {bprod_sh[BSH_W-1], bprod_sh} +
                  {{(SUM_W-ASH_W){acc_sh[ASH_W-1]}}, acc_sh};
      rsp_in.row    = s1_row_ff;
      rsp_in.col    = s1_col_ff;
      rsp_in.offset = s1_offset_ff;
      priority if (&sum[SUM_W-1:sgtm_pkg::C_W-1] || ~|sum[SUM_W-1:sgtm_pkg::C_W-1]) begin
         rsp_in.c_new = sum[sgtm_pkg::C_W-1:0];
      end else if (sum[SUM_W-1]) begin
         rsp_in.c_new = sgtm_pkg::C_MIN;
      end else begin
         rsp_in.c_new = sgtm_pkg::C_MAX;
      end
   end

   // accumulator bank
   always_comb begin
      for (int r = 0; r < sgtm_pkg::TILE_ROWS; r++) begin
         for (int c = 0; c < sgtm_pkg::TILE_COLS; c++) begin
            acc_in[r][c] = acc_ff[r][c];
            if (advance && s1_valid_ff) begin
               if (!s1_finish && s1_col_en_ff[c]) begin
                  acc_in[r][c] = acc_ff[r][c] +
                     {{(sgtm_pkg::ACC_W-PROD_W){s1_prod_ff[r][c][PROD_W-1]}},
                      s1_prod_ff[r][c]};
               end else if (s1_finish && s1_tile_end_ff) begin
                  acc_in[r][c] = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < sgtm_pkg::TILE_ROWS; r++) begin
            for (int c = 0; c < sgtm_pkg::TILE_COLS; c++) begin
               acc_ff[r][c] <= '0;
            end
         end
      end else begin
         acc_ff <= acc_in;
      end
   end

   // response register
   assign rsp_valid_in = advance ? (s1_valid_ff && s1_finish) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff && s1_finish) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- sv/skinny_gemm_tile_mac.sv -----
// A finish request passes the front register, queue, multiply stage and response register.
// Throughput: one item per cycle while rsp_tready does not stall the response register;
// the 16x16 lane and 16x32 beta products are registered before the adds that use them.
// Reset (synchronous): clears the accumulators and the queue, loads the register defaults.
// Depends on sgtm_pkg, sgtm_front, sgtm_queue, sgtm_back and the defines header.
`include "skinny_gemm_tile_mac_defines.svh"
module skinny_gemm_tile_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // a_row0[15:0] a_row1[31:16] a_row2[47:32] a_row3[63:48] b_col0[79:64] b_col1[95:80]
   // c_old[127:96] sel_row[129:128] sel_col[130], zero above
   input  logic [sgtm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,  // kind
   input  logic                                req_tlast,  // tile_end
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // c_new[31:0] out_row[33:32] out_col[34] c_offset[51:35], zero above
   output logic [sgtm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [sgtm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sgtm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   sgtm_pkg::cfg_type    cfg_ff, cfg_in;
   sgtm_pkg::item_type   q_push_item, q_head_item;
   sgtm_pkg::qstat_type  q_stat;
   sgtm_pkg::bstat_type  b_stat;
   sgtm_pkg::rsp_type    rsp_item;
   logic                 q_push, b_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (sgtm_pkg::csr_idx_type'(csr_addr))
            sgtm_pkg::CSR_BETA:      cfg_in.beta           = csr_wdata;
            sgtm_pkg::CSR_ROW_MAJOR: cfg_in.row_major      = csr_wdata[0];
            sgtm_pkg::CSR_LEAD_DIM:  cfg_in.leading_dim    = csr_wdata[sgtm_pkg::LD_W-1:0];
            sgtm_pkg::CSR_COLS:      cfg_in.columns_in_use = csr_wdata[1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beta           <= 16'sd16384;
         cfg_ff.row_major      <= 1'b0;
         cfg_ff.leading_dim    <= 16'd4;
         cfg_ff.columns_in_use <= 2'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sgtm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cfg        (cfg_ff),
      .q_full     (q_stat.full),
      .q_push     (q_push),
      .q_item     (q_push_item)
   );

   sgtm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (b_pop),
      .head_item (q_head_item),
      .stat      (q_stat)
   );

   sgtm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (q_head_item),
      .q_empty    (q_stat.empty),
      .q_pop      (b_pop),
      .beta       (cfg_ff.beta),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item),
      .stat       (b_stat)
   );

   assign rsp_tdata = {{(sgtm_pkg::RSP_TDATA_W - $bits(sgtm_pkg::rsp_type)){1'b0}},
                       rsp_item.offset, rsp_item.col, rsp_item.row, rsp_item.c_new};

   `SGTM_ASSERT_IMP(a_push_room, clock, reset, q_push, !q_stat.full, "push into full queue")
   `SGTM_ASSERT_IMP(a_pop_data, clock, reset, b_pop, !q_stat.empty, "pop from empty queue")
   `SGTM_ASSERT_NXT(a_finish_out, clock, reset, b_stat.s1_valid && b_stat.s1_finish && b_stat.advance, rsp_tvalid, "finish result not presented")
   `SGTM_ASSERT_NXT(a_kstep_quiet, clock, reset, b_stat.s1_valid && !b_stat.s1_finish && b_stat.advance, !rsp_tvalid, "k-step produced a response")

endmodule
